@@ hdl/lcdtpg_pkg.sv @@
// ----------------------------------------------------------------------------
// LCD test pattern generator package
// Register map, pattern mode codes and colour constants.
// ----------------------------------------------------------------------------
package lcdtpg_pkg;

  localparam int SIZE_W  = 11;
  localparam int MODE_W  = 2;
  localparam int PIXEL_W = 16;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [MODE_W-1:0] MODE_BARS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GRAY   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BORDER = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd3;

  localparam logic [SIZE_W-1:0] RESET_WIDTH  = 11'd800;
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = 11'd480;

  localparam logic [PIXEL_W-1:0] PIX_BLACK = 16'h0000;
  // 24-bit white truncated to RGB565
  localparam logic [PIXEL_W-1:0] PIX_WHITE = 16'hFFFF;

  localparam int GRAY_STEPS = 30;
  localparam int GRAY_BANDS = GRAY_STEPS + 1;

  function automatic logic [PIXEL_W-1:0] bar_color(input logic [2:0] band);
    logic [PIXEL_W-1:0] col;
    case (band)
      3'd0:    col = 16'hF800;
      3'd1:    col = 16'h07E0;
      3'd2:    col = 16'h001F;
      3'd3:    col = 16'hFFE0;
      3'd4:    col = 16'hF81F;
      3'd5:    col = 16'h07FF;
      3'd6:    col = PIX_WHITE;
      default: col = PIX_BLACK;
    endcase
    return col;
  endfunction

  function automatic logic [PIXEL_W-1:0] gray_level(input logic [4:0] band);
    logic [PIXEL_W-1:0] lvl;
    if (band == 5'd0) begin
      lvl = PIX_BLACK;
    end else if (band == 5'd31) begin
      lvl = PIX_WHITE;
    end else begin
      lvl = {band, 11'd0} + {5'd0, band, 6'd0} + {11'd0, band};
    end
    return lvl;
  endfunction

endpackage

@@ hdl/lcd_test_pattern_generator_core.sv @@
// ----------------------------------------------------------------------------
// LCD test pattern generator core
// RGB565 raster pattern source with APB-style configuration.
// ----------------------------------------------------------------------------
// Each input transaction produces one pixel, in raster order, at one pixel per
// clock unless out_ready is low with the output register full; the result
// appears in the output register the cycle after acceptance, and the input stays
// ready while that register drains. Band boundaries are held as threshold
// registers recomputed whenever the width or height register is written, so each
// pixel costs only a bank of compares against the column and row counters. A set
// restart bit returns the raster to pixel zero before that pixel is produced.
module lcd_test_pattern_generator_core
  import lcdtpg_pkg::*;
#(
  parameter int COORD_BITS = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_restart,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PIXEL_W-1:0]  out_pixel,
  output logic                out_line_end,
  output logic                out_frame_end
);

  localparam int CB  = COORD_BITS;
  localparam int EXT = (CB > SIZE_W) ? CB : SIZE_W;

  logic [MODE_W-1:0] mode_r;
  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;

  logic [CB-1:0] thr_col_r  [7];
  logic [CB-1:0] thr_row_r  [7];
  logic [CB-1:0] thr_gray_r [GRAY_BANDS];
  logic [CB-1:0] thr_col_nxt  [7];
  logic [CB-1:0] thr_row_nxt  [7];
  logic [CB-1:0] thr_gray_nxt [GRAY_BANDS];

  logic [CB-1:0] col_r, row_r, col_nxt, row_nxt;

  logic               out_valid_r;
  logic [PIXEL_W-1:0] pixel_r;
  logic               line_end_r, frame_end_r;

  logic              wr_en, ld_width, ld_height;
  logic [SIZE_W-1:0] w_src, h_src;
  logic [EXT-1:0]    w_src_ext, h_src_ext, w_cur_ext, h_cur_ext;
  logic [CB-1:0]     w_ld, h_ld, w_cur, h_cur, q8w, q8h, q32, margin;
  logic [CB+4:0]     span30;

  logic               in_fire;
  logic [CB-1:0]      c, r;
  logic               lend, fend, last_row;
  logic [2:0]         cband8, rband8;
  logic [4:0]         gband;
  logic [PIXEL_W-1:0] pix;

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;
  assign ld_width  = !rst_n || (wr_en && paddr[3:2] == REG_WIDTH);
  assign ld_height = !rst_n || (wr_en && paddr[3:2] == REG_HEIGHT);

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_MODE:   prdata = DATA_W'(mode_r);
      REG_WIDTH:  prdata = DATA_W'(width_r);
      REG_HEIGHT: prdata = DATA_W'(height_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_BARS;
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_MODE:   mode_r   <= pwdata[MODE_W-1:0];
        REG_WIDTH:  width_r  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: height_r <= pwdata[SIZE_W-1:0];
        default:    ;
      endcase
    end
  end

  // thresholds: k*(W/8), k*(H/8), and margin + k*(W/32) for the gray ramp
  always_comb begin
    w_src     = rst_n ? pwdata[SIZE_W-1:0] : RESET_WIDTH;
    h_src     = rst_n ? pwdata[SIZE_W-1:0] : RESET_HEIGHT;
    w_src_ext = EXT'(w_src);
    h_src_ext = EXT'(h_src);
    w_ld      = w_src_ext[CB-1:0];
    h_ld      = h_src_ext[CB-1:0];
    q8w       = w_ld >> 3;
    q8h       = h_ld >> 3;
    q32       = w_ld >> 5;
    span30    = (CB+5)'(q32) * (CB+5)'(GRAY_STEPS);
    margin    = CB'(((CB+5)'(w_ld) - span30) >> 1);
    for (int k = 0; k < 7; k++) begin
      thr_col_nxt[k] = CB'((CB+3)'(q8w) * (CB+3)'(k + 1));
      thr_row_nxt[k] = CB'((CB+3)'(q8h) * (CB+3)'(k + 1));
    end
    for (int k = 0; k < GRAY_BANDS; k++) begin
      thr_gray_nxt[k] = CB'((CB+5)'(margin) + (CB+5)'(q32) * (CB+5)'(k));
    end
  end

  always_ff @(posedge clk) begin
    if (ld_width) begin
      thr_col_r  <= thr_col_nxt;
      thr_gray_r <= thr_gray_nxt;
    end
    if (ld_height) begin
      thr_row_r <= thr_row_nxt;
    end
  end

  // ---------------------------------------------------------------- raster
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    w_cur_ext = EXT'(width_r);
    h_cur_ext = EXT'(height_r);
    w_cur     = w_cur_ext[CB-1:0];
    h_cur     = h_cur_ext[CB-1:0];
    c         = in_restart ? '0 : col_r;
    r         = in_restart ? '0 : row_r;
    lend      = ({1'b0, c} + 1'b1) >= {1'b0, w_cur};
    last_row  = ({1'b0, r} + 1'b1) >= {1'b0, h_cur};
    fend      = lend && last_row;

    cband8 = '0;
    rband8 = '0;
    gband  = '0;
    for (int k = 0; k < 7; k++) begin
      if (c >= thr_col_r[k]) cband8 = 3'(k + 1);
      if (r >= thr_row_r[k]) rband8 = 3'(k + 1);
    end
    for (int k = 0; k < GRAY_BANDS; k++) begin
      if (c >= thr_gray_r[k]) gband = 5'(k + 1);
    end

    case (mode_r)
      MODE_BARS:   pix = bar_color(cband8);
      MODE_GRAY:   pix = gray_level(gband);
      MODE_BORDER: pix = (c == '0 || lend || r == '0 || last_row) ? PIX_WHITE : PIX_BLACK;
      default:     pix = (cband8[0] ^ rband8[0]) ? PIX_WHITE : PIX_BLACK;
    endcase

    if (lend) begin
      col_nxt = '0;
      row_nxt = fend ? '0 : r + 1'b1;
    end else begin
      col_nxt = c + 1'b1;
      row_nxt = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pixel_r     <= pix;
      line_end_r  <= lend;
      frame_end_r <= fend;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel     = pixel_r;
  assign out_line_end  = line_end_r;
  assign out_frame_end = frame_end_r;

`ifndef SYNTHESIS
  a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted transaction did not reach the output register");

  a_frame_end_is_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!frame_end_r || line_end_r))
    else $error("frame end without line end");

  a_frame_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && fend |=> col_r == '0 && row_r == '0)
    else $error("raster did not wrap after frame end");

  a_column_steps: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !lend |=> col_r == $past(c) + 1'b1 && row_r == $past(r))
    else $error("column counter did not advance");
`endif

endmodule

@@ bench/tb_lcd_test_pattern_generator_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LCD test pattern generator core testbench
// A directed table is run first, then randomised register settings and
// restart bits under several handshake idling phases. Every pixel is checked
// against the table's expected value if given, else a bench raster predictor.
// ----------------------------------------------------------------------------
module tb_lcd_test_pattern_generator_core;
  import lcdtpg_pkg::*;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               line_end;
    logic               frame_end;
  } pix_txn_t;

  typedef struct packed {
    logic              is_cfg;
    logic [1:0]        reg_idx;
    logic [DATA_W-1:0] value;
    logic              restart;
    logic              typed;
    pix_txn_t          want;
  } stim_row_t;

  // bar colours, bar 0 in the low bits
  localparam logic [8*PIXEL_W-1:0] BAR_RGB = {16'h0000, 16'hFFFF, 16'h07FF, 16'hF81F,
                                              16'hFFE0, 16'h001F, 16'h07E0, 16'hF800};

  logic               clk = 1'b0;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic               in_restart;
  logic               out_valid;
  logic               out_ready;
  logic [PIXEL_W-1:0] out_pixel;
  logic               out_line_end;
  logic               out_frame_end;

  // travels alongside the input transaction
  logic     item_typed;
  pix_txn_t item_want;

  int idle_pct;
  int stall_pct;
  int n_err;
  int n_pix;
  int n_lines;
  int n_frames;
  int n_cfg;

  logic [MODE_W-1:0] mode_r;
  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic [SIZE_W-1:0] ras_col;
  logic [SIZE_W-1:0] ras_row;

  pix_txn_t  pending_pixels[$];
  stim_row_t stim_tab[$];

  lcd_test_pattern_generator_core dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic int unsigned eighth_band(input int unsigned pos, input int unsigned size);
    int unsigned q;
    q = size >> 3;
    if (q == 0) return 7;
    return (pos / q > 7) ? 7 : pos / q;
  endfunction

  function automatic int unsigned gray_band(input int unsigned pos, input int unsigned size);
    int unsigned q, margin, d;
    q      = size >> 5;
    margin = (size - GRAY_STEPS * q) >> 1;
    if (pos < margin) return 0;
    d = pos - margin;
    if (q != 0 && d / q < GRAY_STEPS) return d / q + 1;
    return GRAY_BANDS;
  endfunction

  function automatic pix_txn_t next_pixel(input logic rst_bit);
    int unsigned w, h, c, r, cb, rb;
    pix_txn_t    res;
    w = width_r;
    h = height_r;
    if (rst_bit) begin
      ras_col = '0;
      ras_row = '0;
    end
    c = ras_col;
    r = ras_row;
    res.line_end  = (c + 1 >= w);
    res.frame_end = res.line_end && (r + 1 >= h);
    cb = (mode_r == MODE_GRAY) ? gray_band(c, w) : eighth_band(c, w);
    rb = eighth_band(r, h);
    case (mode_r)
      MODE_BARS: begin
        res.pixel = BAR_RGB[cb*PIXEL_W +: PIXEL_W];
      end
      MODE_GRAY: begin
        if (cb == 0) res.pixel = PIX_BLACK;
        else if (cb >= GRAY_BANDS) res.pixel = PIX_WHITE;
        else res.pixel = PIXEL_W'((cb << 11) + (cb << 6) + cb);
      end
      MODE_BORDER: begin
        res.pixel = (c == 0 || res.line_end || r == 0 || r + 1 >= h) ? PIX_WHITE : PIX_BLACK;
      end
      default: begin
        res.pixel = ((cb + rb) % 2 == 1) ? PIX_WHITE : PIX_BLACK;
      end
    endcase
    if (res.line_end) begin
      ras_col = '0;
      ras_row = res.frame_end ? '0 : SIZE_W'(r + 1);
    end else begin
      ras_col = SIZE_W'(c + 1);
    end
    return res;
  endfunction

  always @(posedge clk) begin : take_input
    pix_txn_t pred;
    if (rst_n && in_valid && in_ready) begin
      pred = next_pixel(in_restart);
      pending_pixels.push_back(item_typed ? item_want : pred);
      n_pix++;
    end
  end

  always @(posedge clk) begin : check_output
    pix_txn_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected transaction: pixel %h with nothing pending", out_pixel);
        n_err++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel !== want.pixel) begin
          $error("pixel: expected %h, got %h", want.pixel, out_pixel);
          n_err++;
        end
        if (out_line_end !== want.line_end) begin
          $error("line_end: expected %b, got %b", want.line_end, out_line_end);
          n_err++;
        end
        if (out_frame_end !== want.frame_end) begin
          $error("frame_end: expected %b, got %b", want.frame_end, out_frame_end);
          n_err++;
        end
      end
      if (out_line_end === 1'b1) n_lines++;
      if (out_frame_end === 1'b1) n_frames++;
    end
  end

  function automatic void add_cfg(input logic [1:0] idx, input int unsigned val);
    stim_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.value   = DATA_W'(val);
    stim_tab.push_back(row);
  endfunction

  function automatic void add_item(input logic rst_bit);
    stim_row_t row;
    row         = '0;
    row.restart = rst_bit;
    stim_tab.push_back(row);
  endfunction

  function automatic void add_check(input logic rst_bit, input logic [PIXEL_W-1:0] pix,
                                    input logic le, input logic fe);
    stim_row_t row;
    row                = '0;
    row.restart        = rst_bit;
    row.typed          = 1'b1;
    row.want.pixel     = pix;
    row.want.line_end  = le;
    row.want.frame_end = fe;
    stim_tab.push_back(row);
  endfunction

  task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] got, field;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MODE: begin
        mode_r = val[MODE_W-1:0];
        field  = DATA_W'(mode_r);
      end
      REG_WIDTH: begin
        width_r = val[SIZE_W-1:0];
        field   = DATA_W'(width_r);
      end
      default: begin
        height_r = val[SIZE_W-1:0];
        field    = DATA_W'(height_r);
      end
    endcase
    n_cfg++;
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== field) begin
      $error("register %0d readback: expected %h, got %h", idx, field, got);
      n_err++;
    end
  endtask

  task automatic send_txn(input logic rst_bit, input logic typed, input pix_txn_t want);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid   <= 1'b1;
    in_restart <= rst_bit;
    item_typed <= typed;
    item_want  <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic random_setting();
    int unsigned w, h, pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) w = $urandom_range(0, 31);
    else if (pick < 75) w = $urandom_range(32, 48);
    else if (pick < 90) w = $urandom_range(49, 300);
    else w = ($urandom_range(0, 1) == 1) ? 2047 : $urandom_range(32, 2047);
    pick = $urandom_range(0, 99);
    if (pick < 30) h = $urandom_range(0, 7);
    else if (pick < 85) h = $urandom_range(8, 12);
    else h = ($urandom_range(0, 1) == 1) ? 2047 : $urandom_range(13, 2047);
    drain();
    reg_write(REG_MODE, $urandom_range(0, 3));
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
  endtask

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    in_restart = 1'b0;
    out_ready  = 1'b0;
    item_typed = 1'b0;
    item_want  = '0;
    idle_pct   = 0;
    stall_pct  = 0;
    n_err      = 0;
    n_pix      = 0;
    n_lines    = 0;
    n_frames   = 0;
    n_cfg      = 0;
    mode_r     = MODE_BARS;
    width_r    = RESET_WIDTH;
    height_r   = RESET_HEIGHT;
    ras_col    = '0;
    ras_row    = '0;

    // directed table
    add_check(1'b0, 16'hF800, 1'b0, 1'b0);
    add_check(1'b1, 16'hF800, 1'b0, 1'b0);
    add_item(1'b0);
    add_cfg(REG_WIDTH, 32);
    add_cfg(REG_HEIGHT, 8);
    add_item(1'b0);
    add_cfg(REG_MODE, MODE_GRAY);
    add_item(1'b0);
    add_check(1'b1, PIX_BLACK, 1'b0, 1'b0);
    add_cfg(REG_WIDTH, 2047);
    add_cfg(REG_HEIGHT, 2047);
    add_item(1'b0);
    add_cfg(REG_MODE, MODE_BORDER);
    add_check(1'b1, PIX_WHITE, 1'b0, 1'b0);
    add_item(1'b0);
    add_cfg(REG_WIDTH, 1);       // shrunk past the current column
    add_item(1'b0);
    add_cfg(REG_HEIGHT, 1);      // shrunk past the current row
    add_item(1'b0);
    add_cfg(REG_WIDTH, 0);
    add_cfg(REG_HEIGHT, 0);
    add_check(1'b0, PIX_WHITE, 1'b1, 1'b1);
    add_cfg(REG_MODE, MODE_CHECK);
    add_cfg(REG_WIDTH, 5);
    add_cfg(REG_HEIGHT, 3);
    add_check(1'b1, PIX_BLACK, 1'b0, 1'b0);
    add_item(1'b0);
    add_item(1'b0);
    add_cfg(REG_MODE, MODE_BARS);
    add_item(1'b0);
    add_cfg(REG_MODE, MODE_GRAY);
    add_cfg(REG_WIDTH, 3);       // no gray steps: black then white
    add_check(1'b1, PIX_BLACK, 1'b0, 1'b0);
    add_check(1'b0, PIX_WHITE, 1'b0, 1'b0);
    add_cfg(REG_MODE, MODE_CHECK);
    add_cfg(REG_WIDTH, 64);
    add_cfg(REG_HEIGHT, 16);
    add_check(1'b1, PIX_BLACK, 1'b0, 1'b0);
    add_item(1'b0);
    add_cfg(REG_MODE, MODE_BARS);
    add_check(1'b1, 16'hF800, 1'b0, 1'b0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_tab[i]) begin
      if (stim_tab[i].is_cfg) begin
        drain();
        reg_write(stim_tab[i].reg_idx, stim_tab[i].value);
      end else begin
        send_txn(stim_tab[i].restart, stim_tab[i].typed, stim_tab[i].want);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 86;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 86;
        end
        default: begin
          idle_pct  = 38;
          stall_pct = 38;
        end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        random_setting();
        repeat ($urandom_range(36, 56)) send_txn($urandom_range(0, 24) == 0, 1'b0, '0);
      end
    end

    drain();
    repeat (4) @(posedge clk);
    $display("Ran %0d pixel transactions over %0d register writes, all four patterns,",
             n_pix, n_cfg);
    $display("tiny to maximum frame sizes; saw %0d line ends and %0d frame ends.",
             n_lines, n_frames);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/lcdtpg_pkg.sv
hdl/lcd_test_pattern_generator_core.sv
bench/tb_lcd_test_pattern_generator_core.sv
